// ===== design/rfr_pkg.sv =====
package rfr_pkg;

    localparam int unsigned OP_W      = 2;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned LEN_W     = 16;
    localparam int unsigned CRC_W     = 16;
    localparam int unsigned TICK_W    = 24;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 24;
    localparam int unsigned M_DATA_W  = 24;

    localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'hFE;
    localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'hFF;
    localparam logic [CRC_W-1:0]  CRC_POLY    = 16'h1021;

    typedef enum logic [OP_W-1:0] {
        OP_BYTE  = 2'd0,
        OP_TICK  = 2'd1,
        OP_START = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OPCODE   = 2'd0,
        CFG_SEED     = 2'd1,
        CFG_TIMEOUT  = 2'd2,
        CFG_CAPACITY = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_SYNC1   = 4'd1,
        PH_SYNC2   = 4'd2,
        PH_OPCODE  = 4'd3,
        PH_LEN_HI  = 4'd4,
        PH_LEN_LO  = 4'd5,
        PH_STATUS  = 4'd6,
        PH_PAYLOAD = 4'd7,
        PH_CRC_HI  = 4'd8,
        PH_CRC_LO  = 4'd9
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] expected_opcode;
        logic [CRC_W-1:0]  crc_seed;
        logic [TICK_W-1:0] timeout_ticks;
        logic [LEN_W-1:0]  payload_capacity;
    } cfg_t;

    typedef struct packed {
        logic              is_verdict;
        logic [BYTE_W-1:0] payload_byte;
        logic              passed;
        logic              timed_out;
        logic [BYTE_W-1:0] frame_status;
    } res_t;

    // CRC-16-CCITT, MSB first, one byte
    function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[CRC_W-1])
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[CRC_W-2:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ===== design/rfr_cfg.sv =====
module rfr_cfg
    import rfr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_DAT_W-1:0] cfg_wdata,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_OPCODE:   cfg_next.expected_opcode  = cfg_wdata[BYTE_W-1:0];
                CFG_SEED:     cfg_next.crc_seed         = cfg_wdata[CRC_W-1:0];
                CFG_TIMEOUT:  cfg_next.timeout_ticks    = cfg_wdata[TICK_W-1:0];
                CFG_CAPACITY: cfg_next.payload_capacity = cfg_wdata[LEN_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.expected_opcode  <= '0;
            cfg_reg.crc_seed         <= 16'hFFFF;
            cfg_reg.timeout_ticks    <= 24'd1000;
            cfg_reg.payload_capacity <= 16'd256;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/rfr_core.sv =====
module rfr_core
    import rfr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [OP_W-1:0]   in_op,
    input  logic [BYTE_W-1:0] in_byte,
    input  logic              res_room,
    output logic              res_push,
    output res_t              res
);

    logic              item_valid_reg;
    logic [OP_W-1:0]   op_reg;
    logic [BYTE_W-1:0] byte_reg;

    phase_t            phase_reg, phase_next;
    logic [LEN_W-1:0]  bytes_left_reg, bytes_left_next;
    logic [CRC_W-1:0]  crc_acc_reg, crc_acc_next;
    logic [BYTE_W-1:0] crc_high_reg, crc_high_next;
    logic [BYTE_W-1:0] status_reg, status_next;
    logic [LEN_W-1:0]  kept_reg, kept_next;
    logic              zero_seen_reg, zero_seen_next;
    logic [TICK_W-1:0] elapsed_reg, elapsed_next;

    logic              advance;
    logic              active;
    logic              late;
    logic              keep;
    logic              emit;
    logic [LEN_W-1:0]  left_dec;
    logic [CRC_W-1:0]  crc_in;
    logic [CRC_W-1:0]  crc_new;
    op_t               op;

    assign advance  = item_valid_reg && res_room;
    assign in_ready = !item_valid_reg || res_room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (in_ready)
            item_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            op_reg   <= in_op;
            byte_reg <= in_byte;
        end
    end

    assign op       = op_t'(op_reg);
    assign active   = (phase_reg != PH_IDLE) && (phase_reg <= PH_CRC_LO);
    assign late     = elapsed_reg > cfg.timeout_ticks;
    assign keep     = kept_reg < cfg.payload_capacity;
    assign emit     = keep && (byte_reg != '0) && !zero_seen_reg;
    assign left_dec = bytes_left_reg - LEN_W'(1);
    // status byte starts from the seed, payload bytes continue the running value
    assign crc_in   = (phase_reg == PH_STATUS) ? cfg.crc_seed : crc_acc_reg;
    assign crc_new  = crc_feed(crc_in, byte_reg);

    // next state
    always_comb
    begin
        phase_next      = phase_reg;
        bytes_left_next = bytes_left_reg;
        crc_acc_next    = crc_acc_reg;
        crc_high_next   = crc_high_reg;
        status_next     = status_reg;
        kept_next       = kept_reg;
        zero_seen_next  = zero_seen_reg;
        elapsed_next    = elapsed_reg;
        if (op == OP_START)
        begin
            phase_next      = PH_SYNC1;
            bytes_left_next = '0;
            crc_acc_next    = '0;
            crc_high_next   = '0;
            status_next     = '0;
            kept_next       = '0;
            zero_seen_next  = 1'b0;
            elapsed_next    = '0;
        end
        else if (active && op == OP_TICK)
        begin
            if (elapsed_reg != '1)
                elapsed_next = elapsed_reg + TICK_W'(1);
        end
        else if (active && op == OP_BYTE)
        begin
            if (late)
                phase_next = PH_IDLE;
            else
            begin
                unique case (phase_reg)
                    PH_SYNC1:
                        if (byte_reg == SYNC_FIRST)
                            phase_next = PH_SYNC2;
                    PH_SYNC2:
                        phase_next = (byte_reg == SYNC_SECOND) ? PH_OPCODE : PH_SYNC1;
                    PH_OPCODE:
                        phase_next = (byte_reg == cfg.expected_opcode) ? PH_LEN_HI
                                                                       : PH_SYNC1;
                    PH_LEN_HI:
                    begin
                        bytes_left_next = {byte_reg, 8'h00};
                        phase_next      = PH_LEN_LO;
                    end
                    PH_LEN_LO:
                    begin
                        bytes_left_next = {bytes_left_reg[LEN_W-1:BYTE_W], byte_reg};
                        phase_next      = PH_STATUS;
                    end
                    PH_STATUS:
                    begin
                        status_next     = byte_reg;
                        crc_acc_next    = crc_new;
                        bytes_left_next = left_dec;
                        kept_next       = '0;
                        zero_seen_next  = 1'b0;
                        phase_next      = (left_dec == '0) ? PH_CRC_HI : PH_PAYLOAD;
                    end
                    PH_PAYLOAD:
                    begin
                        crc_acc_next    = crc_new;
                        bytes_left_next = left_dec;
                        if (keep)
                        begin
                            kept_next = kept_reg + LEN_W'(1);
                            if (byte_reg == '0)
                                zero_seen_next = 1'b1;
                        end
                        if (left_dec == '0)
                            phase_next = PH_CRC_HI;
                    end
                    PH_CRC_HI:
                    begin
                        crc_high_next = byte_reg;
                        phase_next    = PH_CRC_LO;
                    end
                    PH_CRC_LO:
                        phase_next = PH_IDLE;
                    default:
                        phase_next = phase_reg;
                endcase
            end
        end
    end

    // result
    always_comb
    begin
        res_push         = 1'b0;
        res.is_verdict   = 1'b0;
        res.payload_byte = '0;
        res.passed       = 1'b0;
        res.timed_out    = 1'b0;
        res.frame_status = '0;
        if (advance && active && op == OP_BYTE)
        begin
            if (late)
            begin
                res_push         = 1'b1;
                res.is_verdict   = 1'b1;
                res.timed_out    = 1'b1;
                res.frame_status = status_reg;
            end
            else if (phase_reg == PH_PAYLOAD && emit)
            begin
                res_push         = 1'b1;
                res.payload_byte = byte_reg;
            end
            else if (phase_reg == PH_CRC_LO)
            begin
                res_push         = 1'b1;
                res.is_verdict   = 1'b1;
                res.passed       = (status_reg == '0)
                                   && ({crc_high_reg, byte_reg} == crc_acc_reg);
                res.frame_status = status_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            bytes_left_reg <= '0;
            crc_acc_reg    <= '0;
            crc_high_reg   <= '0;
            status_reg     <= '0;
            kept_reg       <= '0;
            zero_seen_reg  <= 1'b0;
            elapsed_reg    <= '0;
        end
        else if (advance)
        begin
            phase_reg      <= phase_next;
            bytes_left_reg <= bytes_left_next;
            crc_acc_reg    <= crc_acc_next;
            crc_high_reg   <= crc_high_next;
            status_reg     <= status_next;
            kept_reg       <= kept_next;
            zero_seen_reg  <= zero_seen_next;
            elapsed_reg    <= elapsed_next;
        end
    end

endmodule

// ===== design/rfr_out_buf.sv =====
module rfr_out_buf
    import rfr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  res_t push_res,
    output logic room,
    output logic out_valid,
    input  logic out_ready,
    output res_t out_res
);

    logic main_valid_reg;
    logic skid_valid_reg;
    res_t main_reg;
    res_t skid_reg;
    logic pop;

    assign pop       = main_valid_reg && out_ready;
    assign room      = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_res   = main_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
                skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            if (main_valid_reg && !pop)
                skid_valid_reg <= 1'b1;
            else
                main_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            main_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                main_reg <= skid_reg;
        end
        else if (push)
        begin
            if (main_valid_reg && !pop)
                skid_reg <= push_res;
            else
                main_reg <= push_res;
        end
    end

endmodule

// ===== design/response_frame_receiver_unit.sv =====
// Path of a result: input register, then the output stage's main register; items
// that cause no result leave nothing. Throughput: one item per cycle while the
// output stage has room; the frame state and CRC update in one step. A two-entry
// output stage keeps input transfers going while a result waits.
// Reset (rst_n, asynchronous, active low): idle, registers to defaults.
module response_frame_receiver_unit
    import rfr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_DAT_W-1:0] cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [BYTE_W-1:0]    s_tdata,   // rx_byte
    input  logic [OP_W-1:0]      s_tuser,   // operation
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_DATA_W-1:0]  m_tdata,   // payload_byte, passed, timed_out, frame_status
    output logic                 m_tuser,   // is_verdict
    output logic                 m_tlast
);

    cfg_t cfg;
    logic res_push;
    logic res_room;
    res_t res;
    res_t out_res;

    rfr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    rfr_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_op    (s_tuser),
        .in_byte  (s_tdata),
        .res_room (res_room),
        .res_push (res_push),
        .res      (res)
    );

    rfr_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_res  (res),
        .room      (res_room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {6'b0, out_res.frame_status, out_res.timed_out, out_res.passed,
                      out_res.payload_byte};
    assign m_tuser = out_res.is_verdict;
    assign m_tlast = out_res.is_verdict;

endmodule

// ===== verif/response_frame_receiver_unit_tb.sv =====
`timescale 1ns / 1ps

module response_frame_receiver_unit_tb;
    import rfr_pkg::*;

    typedef struct packed {
        op_t               op;
        logic [BYTE_W-1:0] data;
    } rx_item_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr  = '0;
    logic [CFG_DAT_W-1:0] cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [BYTE_W-1:0]    s_tdata   = '0;
    logic [OP_W-1:0]      s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;

    rx_item_t rx_items[$];
    res_t     frame_results[$];

    // mirror of the block's registers and frame state
    cfg_t              cfg_m;
    phase_t            f_phase;
    logic [LEN_W-1:0]  f_left;
    logic [CRC_W-1:0]  f_crc;
    logic [BYTE_W-1:0] f_crc_hi;
    logic [BYTE_W-1:0] f_status;
    logic [LEN_W-1:0]  f_kept;
    logic              f_zero;
    logic [TICK_W-1:0] f_ticks;

    int err_cnt  = 0;
    int sent_cnt = 0;
    bit calm     = 1'b0;

    response_frame_receiver_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [CRC_W-1:0] ccitt_next(input logic [CRC_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        logic             fb;
        c = crc;
        for (int i = BYTE_W - 1; i >= 0; i--)
        begin
            fb = c[CRC_W-1] ^ b[i];
            c  = {c[CRC_W-2:0], 1'b0};
            if (fb)
                c = c ^ CRC_POLY;
        end
        return c;
    endfunction

    function automatic void receiver_step(input op_t op, input logic [BYTE_W-1:0] b);
        res_t r;
        r = '0;
        if (op == OP_START)
        begin
            f_phase  = PH_SYNC1;
            f_left   = '0;
            f_crc    = '0;
            f_crc_hi = '0;
            f_status = '0;
            f_kept   = '0;
            f_zero   = 1'b0;
            f_ticks  = '0;
            return;
        end
        if (op == OP_NONE || f_phase == PH_IDLE)
            return;
        if (op == OP_TICK)
        begin
            if (f_ticks != '1)
                f_ticks = f_ticks + TICK_W'(1);
            return;
        end
        // late byte: dropped, frame fails
        if (f_ticks > cfg_m.timeout_ticks)
        begin
            f_phase        = PH_IDLE;
            r.is_verdict   = 1'b1;
            r.timed_out    = 1'b1;
            r.frame_status = f_status;
            frame_results.push_back(r);
            return;
        end
        case (f_phase)
            PH_SYNC1:
                if (b == SYNC_FIRST)
                    f_phase = PH_SYNC2;
            PH_SYNC2:
                f_phase = (b == SYNC_SECOND) ? PH_OPCODE : PH_SYNC1;
            PH_OPCODE:
                f_phase = (b == cfg_m.expected_opcode) ? PH_LEN_HI : PH_SYNC1;
            PH_LEN_HI:
            begin
                f_left  = {b, 8'h00};
                f_phase = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                f_left  = f_left | LEN_W'(b);
                f_phase = PH_STATUS;
            end
            PH_STATUS:
            begin
                f_status = b;
                f_crc    = ccitt_next(cfg_m.crc_seed, b);
                f_left   = f_left - LEN_W'(1);
                f_kept   = '0;
                f_zero   = 1'b0;
                f_phase  = (f_left == '0) ? PH_CRC_HI : PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                f_crc = ccitt_next(f_crc, b);
                if (f_kept < cfg_m.payload_capacity)
                begin
                    f_kept = f_kept + LEN_W'(1);
                    if (b == '0)
                        f_zero = 1'b1;
                    else if (!f_zero)
                    begin
                        r.payload_byte = b;
                        frame_results.push_back(r);
                    end
                end
                f_left = f_left - LEN_W'(1);
                if (f_left == '0)
                    f_phase = PH_CRC_HI;
            end
            PH_CRC_HI:
            begin
                f_crc_hi = b;
                f_phase  = PH_CRC_LO;
            end
            PH_CRC_LO:
            begin
                f_phase        = PH_IDLE;
                r.is_verdict   = 1'b1;
                r.passed       = (f_status == '0) && ({f_crc_hi, b} == f_crc);
                r.frame_status = f_status;
                frame_results.push_back(r);
            end
            default:
                f_phase = PH_IDLE;
        endcase
    endfunction

    task automatic report(input string what, input logic [23:0] got, input logic [23:0] want);
        err_cnt++;
        // keep the log short on a badly broken block
        if (err_cnt <= 40)
            $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
    endtask

    // stream driver: one item per transfer, random gaps
    always @(posedge clk or negedge rst_n)
    begin : drv_proc
        rx_item_t nxt;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                receiver_step(op_t'(s_tuser), s_tdata);
            if (!s_tvalid || s_tready)
            begin
                if (rx_items.size() != 0 && (calm || $urandom_range(99) >= 6))
                begin
                    nxt = rx_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.data;
                    s_tuser  <= nxt.op;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // result monitor: tdata = payload_byte, passed, timed_out, frame_status
    always @(posedge clk or negedge rst_n)
    begin : mon_proc
        res_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (frame_results.size() == 0)
                    report("result with nothing expected", m_tdata, '0);
                else
                begin
                    want = frame_results.pop_front();
                    if (m_tuser !== want.is_verdict)
                        report("is_verdict", 24'(m_tuser), 24'(want.is_verdict));
                    if (m_tdata[7:0] !== want.payload_byte)
                        report("payload_byte", 24'(m_tdata[7:0]), 24'(want.payload_byte));
                    if (m_tdata[8] !== want.passed)
                        report("passed", 24'(m_tdata[8]), 24'(want.passed));
                    if (m_tdata[9] !== want.timed_out)
                        report("timed_out", 24'(m_tdata[9]), 24'(want.timed_out));
                    if (m_tdata[17:10] !== want.frame_status)
                        report("frame_status", 24'(m_tdata[17:10]),
                               24'(want.frame_status));
                    if (m_tlast !== want.is_verdict)
                        report("last", 24'(m_tlast), 24'(want.is_verdict));
                end
            end
            m_tready <= calm || ($urandom_range(99) >= 6);
        end
    end

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DAT_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_OPCODE:   cfg_m.expected_opcode  = val[BYTE_W-1:0];
            CFG_SEED:     cfg_m.crc_seed         = val[CRC_W-1:0];
            CFG_TIMEOUT:  cfg_m.timeout_ticks    = val[TICK_W-1:0];
            CFG_CAPACITY: cfg_m.payload_capacity = val[LEN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [7:0] opc, input logic [15:0] seed,
                             input logic [23:0] tmo, input logic [15:0] cap);
        write_reg(CFG_OPCODE, CFG_DAT_W'(opc));
        write_reg(CFG_SEED, CFG_DAT_W'(seed));
        write_reg(CFG_TIMEOUT, tmo);
        write_reg(CFG_CAPACITY, CFG_DAT_W'(cap));
    endtask

    // all transfers done and all results seen
    task automatic drain();
        while (rx_items.size() != 0 || s_tvalid || frame_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic push_item(input op_t op, input logic [BYTE_W-1:0] b);
        rx_item_t it;
        it.op   = op;
        it.data = b;
        rx_items.push_back(it);
        sent_cnt++;
    endtask

    task automatic push_byte(input logic [BYTE_W-1:0] b, input int tick_pct);
        if ($urandom_range(99) < tick_pct)
            repeat ($urandom_range(1, 3)) push_item(OP_TICK, 8'($urandom_range(0, 255)));
        if ($urandom_range(99) == 0)
            push_item(OP_NONE, 8'($urandom_range(0, 255)));
        push_item(OP_BYTE, b);
    endtask

    // flaw: 0 clean, 1 bad second sync, 2 wrong opcode, 3 restart mid-payload
    task automatic queue_frame(input int plen, input logic [7:0] stat, input bit bad_crc,
                               input int flaw, input int tick_pct, input int zero_pct);
        logic [LEN_W-1:0]  len16;
        logic [CRC_W-1:0]  crc;
        logic [BYTE_W-1:0] b;
        int                cut;
        len16 = 16'(plen + 1);
        cut   = -1;
        if (flaw == 3)
            cut = $urandom_range(0, (plen > 16) ? 16 : plen);
        push_item(OP_START, 8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 2)) push_byte(8'($urandom_range(0, 8'hFD)), tick_pct);
        if (flaw == 1)
        begin
            push_byte(SYNC_FIRST, tick_pct);
            push_byte(8'($urandom_range(0, 8'hFE)), tick_pct);
        end
        else if (flaw == 2)
        begin
            push_byte(SYNC_FIRST, tick_pct);
            push_byte(SYNC_SECOND, tick_pct);
            push_byte(cfg_m.expected_opcode ^ (8'h01 << $urandom_range(0, 7)), tick_pct);
        end
        push_byte(SYNC_FIRST, tick_pct);
        push_byte(SYNC_SECOND, tick_pct);
        push_byte(cfg_m.expected_opcode, tick_pct);
        push_byte(len16[15:8], tick_pct);
        push_byte(len16[7:0], tick_pct);
        push_byte(stat, tick_pct);
        crc = ccitt_next(cfg_m.crc_seed, stat);
        for (int i = 0; i < plen; i++)
        begin
            if (i == cut)
            begin
                push_item(OP_START, 8'($urandom_range(0, 255)));
                return;
            end
            b = ($urandom_range(99) < zero_pct) ? 8'h00 : 8'($urandom_range(1, 255));
            crc = ccitt_next(crc, b);
            push_byte(b, tick_pct);
        end
        if (bad_crc)
            crc = crc ^ (16'h0001 << $urandom_range(0, 15));
        push_byte(crc[15:8], tick_pct);
        push_byte(crc[7:0], tick_pct);
    endtask

    initial
    begin : stim_proc
        int          sess;
        int          rand_end;
        int          n_frames;
        int          plen;
        int          flaw;
        int          tick_pct;
        int          pick;
        logic [7:0]  op_v;
        logic [15:0] seed_v;
        logic [23:0] tmo_v;
        logic [15:0] cap_v;

        cfg_m.expected_opcode  = 8'h00;
        cfg_m.crc_seed         = 16'hFFFF;
        cfg_m.timeout_ticks    = 24'd1000;
        cfg_m.payload_capacity = 16'd256;
        f_phase  = PH_IDLE;
        f_left   = '0;
        f_crc    = '0;
        f_crc_hi = '0;
        f_status = '0;
        f_kept   = '0;
        f_zero   = 1'b0;
        f_ticks  = '0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: ignored items while idle, length one, bad CRC with status,
        // zero length field cut short by a restart, timeout
        write_all(8'h3C, 16'hFFFF, 24'd3, 16'd2);
        push_item(OP_BYTE, 8'hFF);
        push_item(OP_TICK, 8'h00);
        push_item(OP_NONE, 8'hA5);
        queue_frame(0, 8'h00, 1'b0, 0, 0, 0);
        queue_frame(3, 8'h80, 1'b1, 0, 0, 50);
        queue_frame(65535, 8'h00, 1'b0, 3, 0, 0);
        push_item(OP_START, 8'h00);
        repeat (4) push_item(OP_TICK, 8'hFF);
        push_item(OP_BYTE, SYNC_FIRST);

        rand_end = sent_cnt + 1700;
        for (sess = 0; sent_cnt < rand_end; sess++)
        begin
            drain();
            calm     = (sess == 3 || sess == 4);
            tick_pct = 0;
            case (sess)
                0:
                begin
                    op_v   = 8'h00;
                    seed_v = 16'h0000;
                    tmo_v  = 24'hFFFFFF;
                    cap_v  = 16'hFFFF;
                end
                1:
                begin
                    op_v     = 8'hFF;
                    seed_v   = 16'hFFFF;
                    tmo_v    = 24'h000000;
                    cap_v    = 16'h0000;
                    tick_pct = 25;
                end
                default:
                begin
                    op_v   = 8'($urandom_range(0, 255));
                    seed_v = 16'($urandom_range(0, 16'hFFFF));
                    pick   = $urandom_range(0, 4);
                    case (pick)
                        0: tmo_v = 24'd0;
                        1: tmo_v = 24'($urandom_range(1, 8));
                        2: tmo_v = 24'($urandom_range(20, 200));
                        3: tmo_v = 24'hFFFFFF;
                        default: tmo_v = 24'($urandom_range(0, 24'hFFFFFF));
                    endcase
                    pick = $urandom_range(0, 4);
                    case (pick)
                        0: cap_v = 16'd0;
                        1: cap_v = 16'($urandom_range(1, 6));
                        2: cap_v = 16'($urandom_range(7, 40));
                        3: cap_v = 16'hFFFF;
                        default: cap_v = 16'($urandom_range(0, 16'hFFFF));
                    endcase
                    pick = $urandom_range(0, 2);
                    tick_pct = (pick == 0) ? 0 : (pick == 1) ? 4 : 25;
                end
            endcase
            write_all(op_v, seed_v, tmo_v, cap_v);

            n_frames = $urandom_range(8, 20);
            repeat (n_frames)
            begin
                if ($urandom_range(99) < 5)
                    push_item($urandom_range(1) ? OP_BYTE : OP_TICK,
                              8'($urandom_range(0, 255)));
                pick = $urandom_range(99);
                flaw = (pick < 80) ? 0 : (pick < 87) ? 1 : (pick < 93) ? 2 : 3;
                pick = $urandom_range(99);
                plen = (pick < 70) ? $urandom_range(0, 8) : $urandom_range(9, 40);
                // zero length field, cut short by a restart
                if ($urandom_range(99) == 0)
                begin
                    plen = 65535;
                    flaw = 3;
                end
                queue_frame(plen,
                            ($urandom_range(99) < 15) ? 8'($urandom_range(1, 255)) : 8'h00,
                            $urandom_range(99) < 15, flaw, tick_pct,
                            ($urandom_range(3) == 0) ? 15 : 0);
            end
        end

        drain();
        if (err_cnt == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== files.f =====
design/rfr_pkg.sv
design/rfr_cfg.sv
design/rfr_core.sv
design/rfr_out_buf.sv
design/response_frame_receiver_unit.sv
verif/response_frame_receiver_unit_tb.sv
